### rtl/mcvc_pkg.sv
// ----------------------------------------------------------------------------
// mcvc_pkg
// Shared types, widths and arithmetic helpers for the min-cost volume cover
// dynamic-programming block.
// ----------------------------------------------------------------------------
package mcvc_pkg;

  // Default row size: volumes 0..DEF_MAX_TARGET
  localparam int DEF_MAX_TARGET = 1024;

  // Field widths
  localparam int COST_W      = 32;
  localparam int DIST_W      = 9;
  localparam int ITEM_COST_W = 16;
  localparam int VOL_W       = 11;
  localparam int TGT_W       = 11;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register indexes
  localparam int REG_TARGET = 0;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Saturation values
  localparam logic [COST_W-1:0] COST_NONE = {COST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  // One DP entry: least cost and distinct kinds used
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [DIST_W-1:0] kinds;
  } entry_t;

  // One queued item kind
  typedef struct packed {
    logic [ITEM_COST_W-1:0] cost;
    logic [VOL_W-1:0]       vol;
    logic                   last;
  } item_t;

  // Add an item cost, stopping at all-ones
  function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W-1:0]      a,
                                                 input logic [ITEM_COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W + 1)'(b);
    return s[COST_W] ? COST_NONE : s[COST_W-1:0];
  endfunction

  // Count one more distinct kind, stopping at all-ones
  function automatic logic [DIST_W-1:0] sat_dist(input logic [DIST_W-1:0] d);
    return (d == DIST_MAX) ? DIST_MAX : d + DIST_W'(1);
  endfunction

  // True when a beats b: lower cost, or equal cost with more distinct kinds
  function automatic logic wins(input entry_t a, input entry_t b);
    return (a.cost < b.cost) || ((a.cost == b.cost) && (a.kinds > b.kinds));
  endfunction

endpackage

### rtl/mcvc_front.sv
// ----------------------------------------------------------------------------
// mcvc_front
// Input side: accepts item kinds on the start/busy handshake and holds them
// in a short queue until the DP sequencer takes them.
// ----------------------------------------------------------------------------
module mcvc_front
  import mcvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ITEM_COST_W-1:0] in_item_cost,
  input  logic [VOL_W-1:0]       in_item_volume,
  input  logic                   in_last_item,
  input  logic                   clearing,
  output logic                   busy,
  output logic                   q_valid,
  output item_t                  q_item,
  input  logic                   q_pop
);

  item_t             buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  // Hold off new items when the queue is full or the rows are being cleared
  assign busy    = (count_r == QCNT_W'(QUEUE_DEPTH)) || clearing;
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = buf_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the accepted transfer
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= '{cost: in_item_cost, vol: in_item_volume, last: in_last_item};
    end
  end

endmodule

### rtl/mcvc_bank.sv
// ----------------------------------------------------------------------------
// mcvc_bank
// One DP row: single write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcvc_bank
  import mcvc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_TARGET + 1,
  parameter int AW    = $clog2(DEF_MAX_TARGET + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output entry_t        ra_data,
  output entry_t        rb_data
);

  entry_t mem [DEPTH];
  entry_t ra_data_r;
  entry_t rb_data_r;

  // Write one entry, read two
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data_r <= mem[ra_addr];
    rb_data_r <= mem[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

### rtl/mcvc_back.sv
// ----------------------------------------------------------------------------
// mcvc_back
// DP sequencer: walks one row entry per cycle through a three-stage pipeline
// (read, combine with previous row, combine with new row), ping-pongs the two
// row banks, emits the result on the last item and clears both rows.
// ----------------------------------------------------------------------------
module mcvc_back
  import mcvc_pkg::*;
#(
  parameter int MAX_TARGET = DEF_MAX_TARGET
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TGT_W-1:0]  target,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  output logic [COST_W-1:0] out_min_cost,
  output logic [DIST_W-1:0] out_distinct_used
);

  localparam int ROW_LEN = MAX_TARGET + 1;
  localparam int AW      = $clog2(ROW_LEN);
  localparam int XW      = (AW > VOL_W) ? ((AW > TGT_W) ? AW : TGT_W)
                                        : ((VOL_W > TGT_W) ? VOL_W : TGT_W);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ROW_LEN - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  state_t  state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          row_sel_r, row_sel_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Current item
  logic [ITEM_COST_W-1:0] cost_r;
  logic [VOL_W-1:0]       vol_r;
  logic                   last_r;
  logic [AW-1:0]          t_r;
  logic [AW-1:0]          t_clamp;
  logic [XW-1:0]          tgt_ext;

  // Issue stage
  logic          iss_v;
  logic [XW-1:0] j_ext;
  logic [XW-1:0] vol_ext;
  logic [XW-1:0] j_minus_v;
  logic [AW-1:0] p_now;
  logic          same_now;
  logic          fwd_now;

  // Stage 1 / stage 2 registers
  logic          s1_v_r;
  logic [AW-1:0] s1_j_r;
  logic [AW-1:0] s1_p_r;
  logic          s1_same_r;
  logic          s1_fwd_r;
  logic          s2_v_r;
  logic [AW-1:0] s2_j_r;
  entry_t        s2_x_r;
  logic          s2_same_r;
  logic          s2_fwd_r;
  entry_t        res_last_r;
  logic [COST_W-1:0] out_cost_r;
  logic [DIST_W-1:0] out_dist_r;

  // Bank ports
  logic          b0_we, b1_we;
  logic [AW-1:0] b0_waddr, b1_waddr;
  entry_t        b0_wdata, b1_wdata;
  logic [AW-1:0] b0_ra, b1_ra;
  entry_t        b0_rda, b0_rdb, b1_rda, b1_rdb;

  entry_t prev_j, prev_p, new_p_mem, new_p;
  entry_t cand_b, cand_x, cand_c, res;
  entry_t clr_data;
  logic   fin_hit;

  // Clamp the target to the row size
  assign tgt_ext = XW'(target);
  assign t_clamp = (tgt_ext > XW'(MAX_TARGET)) ? AW'(MAX_TARGET) : tgt_ext[AW-1:0];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    j_nxt       = j_r;
    row_sel_nxt = row_sel_r;
    q_pop       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          clr_nxt     = '0;
          row_sel_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          j_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        j_nxt = j_r + AW'(1);
        if (j_r == t_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        row_sel_nxt = ~row_sel_r;
        if (last_r) begin
          clr_nxt   = '0;
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign fin_hit       = s2_v_r && (s2_j_r == t_r) && last_r;
  assign out_valid_nxt = fin_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      j_r         <= '0;
      row_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_cost_r  <= '0;
      out_dist_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      j_r         <= j_nxt;
      row_sel_r   <= row_sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_hit) begin
        out_cost_r <= res.cost;
        out_dist_r <= res.kinds;
      end
    end
  end

  // Latch the item taken from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cost_r <= q_item.cost;
      vol_r  <= q_item.vol;
      last_r <= q_item.last;
      t_r    <= t_clamp;
    end
  end

  // Issue: source index p = max(0, j - volume)
  assign iss_v     = (state_r == ST_RUN);
  assign j_ext     = XW'(j_r);
  assign vol_ext   = XW'(vol_r);
  assign j_minus_v = j_ext - vol_ext;
  assign p_now     = (j_ext > vol_ext) ? j_minus_v[AW-1:0] : '0;
  assign same_now  = (p_now == j_r);
  assign fwd_now   = ({1'b0, p_now} + (AW + 1)'(1)) == {1'b0, j_r};

  // Stage 1: best of previous row entry and one more unit on previous row
  assign prev_j       = row_sel_r ? b1_rda : b0_rda;
  assign prev_p       = row_sel_r ? b1_rdb : b0_rdb;
  assign cand_b.cost  = sat_cost(prev_p.cost, cost_r);
  assign cand_b.kinds = sat_dist(prev_p.kinds);
  assign cand_x       = wins(prev_j, cand_b) ? prev_j : cand_b;

  // Stage 2: one more unit on the new row; forward the entry just finished
  assign new_p_mem    = row_sel_r ? b0_rda : b1_rda;
  assign new_p        = s2_fwd_r ? res_last_r : new_p_mem;
  assign cand_c.cost  = sat_cost(new_p.cost, cost_r);
  assign cand_c.kinds = new_p.kinds;
  assign res          = (!s2_same_r && wins(cand_c, s2_x_r)) ? cand_c : s2_x_r;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_j_r    <= j_r;
    s1_p_r    <= p_now;
    s1_same_r <= same_now;
    s1_fwd_r  <= fwd_now;
    s2_j_r    <= s1_j_r;
    s2_x_r    <= cand_x;
    s2_same_r <= s1_same_r;
    s2_fwd_r  <= s1_fwd_r;
    if (s2_v_r) begin
      res_last_r <= res;
    end
  end

  // Bank control: clear both rows, or write the new row
  assign clearing       = (state_r == ST_CLEAR);
  assign clr_data.cost  = (clr_r == '0) ? '0 : COST_NONE;
  assign clr_data.kinds = '0;

  assign b0_we    = clearing || (s2_v_r && row_sel_r);
  assign b1_we    = clearing || (s2_v_r && !row_sel_r);
  assign b0_waddr = clearing ? clr_r : s2_j_r;
  assign b1_waddr = clearing ? clr_r : s2_j_r;
  assign b0_wdata = clearing ? clr_data : res;
  assign b1_wdata = clearing ? clr_data : res;
  assign b0_ra    = row_sel_r ? s1_p_r : j_r;
  assign b1_ra    = row_sel_r ? j_r : s1_p_r;

  mcvc_bank #(
    .DEPTH (ROW_LEN),
    .AW    (AW)
  ) u_bank0 (
    .clk     (clk),
    .we      (b0_we),
    .waddr   (b0_waddr),
    .wdata   (b0_wdata),
    .ra_addr (b0_ra),
    .rb_addr (p_now),
    .ra_data (b0_rda),
    .rb_data (b0_rdb)
  );

  mcvc_bank #(
    .DEPTH (ROW_LEN),
    .AW    (AW)
  ) u_bank1 (
    .clk     (clk),
    .we      (b1_we),
    .waddr   (b1_waddr),
    .wdata   (b1_wdata),
    .ra_addr (b1_ra),
    .rb_addr (p_now),
    .ra_data (b1_rda),
    .rb_data (b1_rdb)
  );

  assign out_valid         = out_valid_r;
  assign out_min_cost      = out_cost_r;
  assign out_distinct_used = out_dist_r;

endmodule

### rtl/min_cost_volume_cover_dp.sv
// ----------------------------------------------------------------------------
// min_cost_volume_cover_dp
// Unbounded-knapsack min-cost cover: least cost reaching a target volume.
// ----------------------------------------------------------------------------
// Each item kind is taken from the queue, then the sequencer walks row
// entries 0..min(target_volume, MAX_TARGET) at one DP entry per cycle
// through the row banks' read ports, then drains the pipeline. Up to two items
// queue ahead of the sequencer. After reset, and after every item marked
// last, both rows are cleared (MAX_TARGET + 1 entries) while busy is high.
// The result of a last item shows on out_valid for a single cycle, once it
// is through the s1, s2 and output registers; the receiver cannot stall it
// and must take it in that cycle. Write target_volume only while idle.
module min_cost_volume_cover_dp
  import mcvc_pkg::*;
#(
  parameter int MAX_TARGET = DEF_MAX_TARGET
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Item input
  input  logic                   start,
  output logic                   busy,
  input  logic [ITEM_COST_W-1:0] in_item_cost,
  input  logic [VOL_W-1:0]       in_item_volume,
  input  logic                   in_last_item,
  // Result output
  output logic                   out_valid,
  output logic [COST_W-1:0]      out_min_cost,
  output logic [DIST_W-1:0]      out_distinct_used,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [TGT_W-1:0] target_r;
  logic             cfg_wr;
  logic             clearing;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  // Register file: one word per register, index in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_TARGET));
  assign prdata = (paddr[2] == 1'(REG_TARGET)) ? APB_DW'(target_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr) begin
      target_r <= pwdata[TGT_W-1:0];
    end
  end

  mcvc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_item_cost   (in_item_cost),
    .in_item_volume (in_item_volume),
    .in_last_item   (in_last_item),
    .clearing       (clearing),
    .busy           (busy),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mcvc_back #(
    .MAX_TARGET (MAX_TARGET)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .target            (target_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_min_cost      (out_min_cost),
    .out_distinct_used (out_distinct_used)
  );

endmodule
